/* hdl/ftfps_pkg.sv */
// shared types and constants of the frame timer
package ftfps_pkg;

  localparam int unsigned WINDOW_DEF = 64;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [31:0] COUNTER_HZ_RST = 32'd10000000;
  localparam logic [32:0] ACC_MAX = 33'h1_FFFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COUNTER_HZ = 1'b0,
    CFG_MIN_FRAME  = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2,
    KIND_RESET = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIFF,
    OP_APPLY,
    OP_GATE,
    OP_SUB_OLD,
    OP_PUSH,
    OP_DIV,
    OP_TOTAL,
    OP_OUT
  } op_t;

  typedef struct packed {
    logic tick_go;
    logic push_ok;
    logic full;
    logic cnt_zero;
    logic div_done;
  } status_t;

endpackage

/* hdl/ftfps_ram.sv */
// generic single write port ram with registered read
module ftfps_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/ftfps_div.sv */
// restoring serial divider, one quotient bit per cycle
module ftfps_div #(
  parameter int unsigned N = 39,
  parameter int unsigned D = 7
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quotient
);

  localparam int unsigned CW = $clog2(N + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [N-1:0]  q_r;
  logic [D-1:0]  rem_r;
  logic [D-1:0]  div_r;

  logic [D:0]    shift;
  logic          ge;
  logic [D-1:0]  rem_nxt;
  logic [N-1:0]  q_nxt;
  logic [D:0]    sub;

  always_comb begin
    shift   = {rem_r, q_r[N-1]};
    ge      = (shift >= {1'b0, div_r});
    sub     = shift - {1'b0, div_r};
    rem_nxt = ge ? sub[D-1:0] : shift[D-1:0];
    q_nxt   = {q_r[N-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(N);
        q_r    <= dividend;
        rem_r  <= '0;
        div_r  <= divisor;
      end else if (busy_r) begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

/* hdl/ftfps_dp.sv */
// datapath: timer state, sample window, running sum and output registers
module ftfps_dp #(
  parameter int unsigned WINDOW = ftfps_pkg::WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ftfps_pkg::op_t                  cmd,
  output ftfps_pkg::status_t              status,
  input  logic                            cfg_we,
  input  logic [ftfps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                     cfg_data,
  input  logic [1:0]                      in_kind,
  input  logic [63:0]                     in_timestamp,
  output logic [31:0]                     out_average_frame_ticks,
  output logic [31:0]                     out_frames_per_second,
  output logic [63:0]                     out_total_ticks,
  output logic                            out_is_stopped,
  output logic                            out_must_wait
);

  localparam int unsigned HEAD_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = 32 + CNT_W;

  logic [31:0] hz_r;
  logic [31:0] min_r;

  ftfps_pkg::kind_t kind_r;
  logic [63:0] ts_r;
  logic [63:0] diff_r;
  logic [63:0] absdiff_r;
  logic [31:0] sample_r;
  logic [63:0] tot_r;
  logic        wait_r;

  logic [63:0] last_r;
  logic [63:0] current_r;
  logic [63:0] base_r;
  logic [63:0] paused_r;
  logic [63:0] stop_r;
  logic        stopped_r;
  logic [HEAD_W-1:0] head_r;
  logic [CNT_W-1:0]  count_r;
  logic [SUM_W-1:0]  sum_r;
  logic [31:0] avg_r;
  logic [31:0] frames_r;
  logic [32:0] acc_r;
  logic [31:0] rate_r;

  logic [31:0] avg_o_r;
  logic [31:0] rate_o_r;
  logic [63:0] total_o_r;
  logic        stopped_o_r;
  logic        wait_o_r;

  logic [63:0] sub_b;
  logic        lock_hold;
  logic [63:0] absdiff_nxt;
  logic [64:0] acc_sum;
  logic [32:0] acc_nxt;
  logic [31:0] sample_nxt;
  logic        full;
  logic        push_ok;
  logic        ram_re;
  logic        ram_we;
  logic [31:0] ram_rdata;
  logic        div_start;
  logic        div_done;
  logic [SUM_W-1:0] quot;
  logic [63:0] stamp_sel;

  always_comb begin
    sub_b       = (kind_r == ftfps_pkg::KIND_START) ? stop_r : last_r;
    lock_hold   = (min_r != 32'd0) && (diff_r < {32'd0, min_r});
    absdiff_nxt = (diff_r >= {32'd0, avg_r}) ? diff_r - {32'd0, avg_r}
                                             : {32'd0, avg_r} - diff_r;
    acc_sum     = {32'd0, acc_r} + {1'b0, diff_r};
    acc_nxt     = (acc_sum > {32'd0, ftfps_pkg::ACC_MAX}) ? ftfps_pkg::ACC_MAX
                                                         : acc_sum[32:0];
    sample_nxt  = (diff_r[63:32] != 32'd0) ? 32'hFFFF_FFFF : diff_r[31:0];
    full        = (count_r == CNT_W'(WINDOW));
    push_ok     = (absdiff_r < {32'd0, hz_r});
    ram_re      = (cmd == ftfps_pkg::OP_GATE) && push_ok && full;
    ram_we      = (cmd == ftfps_pkg::OP_PUSH);
    div_start   = (cmd == ftfps_pkg::OP_DIV) && (count_r != '0);
    stamp_sel   = stopped_r ? stop_r : current_r;
  end

  assign status.tick_go  = (kind_r == ftfps_pkg::KIND_TICK) && !stopped_r && !lock_hold;
  assign status.push_ok  = push_ok;
  assign status.full     = full;
  assign status.cnt_zero = (count_r == '0);
  assign status.div_done = div_done;

  ftfps_ram #(
    .WIDTH (32),
    .DEPTH (WINDOW)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head_r),
    .wdata (sample_r),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  ftfps_div #(
    .N (SUM_W),
    .D (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (quot)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hz_r  <= ftfps_pkg::COUNTER_HZ_RST;
      min_r <= 32'd0;
    end else if (cfg_we) begin
      unique case (ftfps_pkg::cfg_idx_t'(cfg_index))
        ftfps_pkg::CFG_COUNTER_HZ: hz_r  <= cfg_data;
        ftfps_pkg::CFG_MIN_FRAME:  min_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-item working registers and output registers
  always_ff @(posedge clk) begin
    case (cmd)
      ftfps_pkg::OP_LOAD: begin
        kind_r <= ftfps_pkg::kind_t'(in_kind);
        ts_r   <= in_timestamp;
        wait_r <= 1'b0;
      end
      ftfps_pkg::OP_DIFF: begin
        diff_r <= ts_r - sub_b;
      end
      ftfps_pkg::OP_APPLY: begin
        absdiff_r <= absdiff_nxt;
        sample_r  <= sample_nxt;
        if (kind_r == ftfps_pkg::KIND_TICK && !stopped_r && lock_hold) begin
          wait_r <= 1'b1;
        end
      end
      ftfps_pkg::OP_TOTAL: begin
        tot_r <= stamp_sel - paused_r;
      end
      ftfps_pkg::OP_OUT: begin
        avg_o_r     <= avg_r;
        rate_o_r    <= rate_r;
        total_o_r   <= tot_r - base_r;
        stopped_o_r <= stopped_r;
        wait_o_r    <= wait_r;
      end
      default: ;
    endcase
  end

  // architectural timer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r    <= '0;
      current_r <= '0;
      base_r    <= '0;
      paused_r  <= '0;
      stop_r    <= '0;
      stopped_r <= 1'b0;
      head_r    <= '0;
      count_r   <= '0;
      sum_r     <= '0;
      avg_r     <= '0;
      frames_r  <= '0;
      acc_r     <= '0;
      rate_r    <= '0;
    end else begin
      case (cmd)
        ftfps_pkg::OP_APPLY: begin
          case (kind_r)
            ftfps_pkg::KIND_TICK: begin
              if (stopped_r) begin
                avg_r <= '0;
              end else if (!lock_hold) begin
                current_r <= ts_r;
                last_r    <= ts_r;
                if (frames_r != 32'hFFFF_FFFF) begin
                  frames_r <= frames_r + 32'd1;
                end
                acc_r <= acc_nxt;
              end
            end
            ftfps_pkg::KIND_START: begin
              if (stopped_r) begin
                paused_r  <= paused_r + diff_r;
                last_r    <= ts_r;
                stop_r    <= '0;
                stopped_r <= 1'b0;
              end
            end
            ftfps_pkg::KIND_STOP: begin
              if (!stopped_r) begin
                stop_r    <= ts_r;
                stopped_r <= 1'b1;
              end
            end
            default: begin
              base_r    <= ts_r;
              last_r    <= ts_r;
              stop_r    <= '0;
              paused_r  <= '0;
              stopped_r <= 1'b0;
            end
          endcase
        end
        ftfps_pkg::OP_GATE: begin
          if (acc_r > {1'b0, hz_r}) begin
            rate_r   <= frames_r;
            frames_r <= '0;
            acc_r    <= '0;
          end
        end
        ftfps_pkg::OP_SUB_OLD: begin
          sum_r <= sum_r - SUM_W'(ram_rdata);
        end
        ftfps_pkg::OP_PUSH: begin
          sum_r <= sum_r + SUM_W'(sample_r);
          if (!full) begin
            count_r <= count_r + 1'b1;
          end
          if (head_r == HEAD_W'(WINDOW - 1)) begin
            head_r <= '0;
          end else begin
            head_r <= head_r + 1'b1;
          end
        end
        ftfps_pkg::OP_DIV: begin
          if (count_r == '0) begin
            avg_r <= '0;
          end
        end
        default: ;
      endcase
      if (div_done) begin
        avg_r <= quot[31:0];
      end
    end
  end

  assign out_average_frame_ticks = avg_o_r;
  assign out_frames_per_second   = rate_o_r;
  assign out_total_ticks         = total_o_r;
  assign out_is_stopped          = stopped_o_r;
  assign out_must_wait           = wait_o_r;

endmodule

/* hdl/ftfps_ctrl.sv */
// controller: sequences one item through the datapath and owns the handshakes
module ftfps_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  ftfps_pkg::status_t status,
  output ftfps_pkg::op_t     cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_APPLY,
    S_GATE,
    S_READ,
    S_PUSH,
    S_DIVS,
    S_DIVW,
    S_TOTAL,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = ftfps_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = ftfps_pkg::OP_LOAD;
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd       = ftfps_pkg::OP_DIFF;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd       = ftfps_pkg::OP_APPLY;
        state_nxt = status.tick_go ? S_GATE : S_TOTAL;
      end
      S_GATE: begin
        cmd = ftfps_pkg::OP_GATE;
        if (!status.push_ok) begin
          state_nxt = S_DIVS;
        end else if (status.full) begin
          state_nxt = S_READ;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_READ: begin
        cmd       = ftfps_pkg::OP_SUB_OLD;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        cmd       = ftfps_pkg::OP_PUSH;
        state_nxt = S_DIVS;
      end
      S_DIVS: begin
        cmd       = ftfps_pkg::OP_DIV;
        state_nxt = status.cnt_zero ? S_TOTAL : S_DIVW;
      end
      S_DIVW: begin
        if (status.div_done) begin
          state_nxt = S_TOTAL;
        end
      end
      S_TOTAL: begin
        cmd       = ftfps_pkg::OP_TOTAL;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd       = ftfps_pkg::OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* hdl/frame_timer_with_fps_average.sv */
// frame timer top level: moving-average frame time and frames-per-second latch
// start, stop, reset, held ticks and ticks while stopped pass the load, diff, apply,
// total and done states; a running tick adds gate, optional read and push, and divide
// states, and with a non-empty window waits on the serial divider producing one quotient
// bit per cycle; one item is in flight, and the next is taken only once its result is issued
// synchronous active-low reset clears timer state, window bookkeeping and handshakes
module frame_timer_with_fps_average #(
  parameter int unsigned WINDOW = ftfps_pkg::WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_kind,
  input  logic [63:0]                     in_timestamp,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [31:0]                     out_average_frame_ticks,
  output logic [31:0]                     out_frames_per_second,
  output logic [63:0]                     out_total_ticks,
  output logic                            out_is_stopped,
  output logic                            out_must_wait,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ftfps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                     cfg_data
);

  ftfps_pkg::op_t     cmd;
  ftfps_pkg::status_t status;

  assign cfg_ready = 1'b1;

  ftfps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ftfps_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cmd                     (cmd),
    .status                  (status),
    .cfg_we                  (cfg_valid),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data),
    .in_kind                 (in_kind),
    .in_timestamp            (in_timestamp),
    .out_average_frame_ticks (out_average_frame_ticks),
    .out_frames_per_second   (out_frames_per_second),
    .out_total_ticks         (out_total_ticks),
    .out_is_stopped          (out_is_stopped),
    .out_must_wait           (out_must_wait)
  );

endmodule
